// ===== sv/vc_pkg.sv =====
// Shared types, constants and helper functions for the varint codec.
// Depends on nothing; used by vc_group_unit and varint_codec_top.
`timescale 1ns / 1ps

package vc_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int GROUP_BITS     = 7;
    localparam int MAX_GROUPS     = 10;
    localparam int WIDE_BITS      = GROUP_BITS * MAX_GROUPS;
    localparam int LIMIT_32       = 32;
    localparam int LIMIT_64       = 64;
    localparam int IN_DATA_BITS   = 72;
    localparam int OUT_DATA_BITS  = 72;
    localparam int CFG_DATA_BITS  = 4;

    // Register indexes on the configuration port
    typedef enum logic [0:0] {
        CFG_DECODE_LIMIT = 1'b0,
        CFG_ENCODE_CAP   = 1'b1
    } cfg_index_t;

    // Item kinds carried on the input tuser bit
    typedef enum logic [0:0] {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC_CHECK,
        ST_ENC_EMIT,
        ST_DEC
    } state_t;

    // Request to the shared group unit
    typedef struct packed {
        logic [3:0] grp_idx;   // group position to extract or place
        logic [3:0] mask_idx;  // first group position tested for nonzero bits
    } grp_req_t;

    // Status back from the shared group unit
    typedef struct packed {
        logic [GROUP_BITS-1:0] group;  // extracted 7-bit group
        logic                  hi_nz;  // any bit set at or above the mask position
    } grp_res_t;

    // Mask with every bit at position 7*k and above set
    function automatic logic [63:0] hi_mask64(input logic [3:0] k);
        logic [63:0] m;
        for (int j = 0; j < 64; j++) begin
            m[j] = (j >= GROUP_BITS * int'(k));
        end
        return m;
    endfunction

    // Bit length of a 7-bit group
    function automatic logic [2:0] bit_len7(input logic [GROUP_BITS-1:0] b);
        logic [2:0] n;
        n = 3'd0;
        for (int j = 0; j < GROUP_BITS; j++) begin
            if (b[j])
            begin
                n = 3'(j + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/vc_group_unit.sv =====
// Shared 7-bit group unit: extracts or places one group at a chosen position
// and tests the word for set bits above a group boundary. Uses vc_pkg.
`timescale 1ns / 1ps

module vc_group_unit #(
    parameter int VALUE_BITS = vc_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0]          word,
    input  logic [vc_pkg::GROUP_BITS-1:0]  grp,
    input  vc_pkg::grp_req_t               req,
    output logic [VALUE_BITS-1:0]          placed,
    output vc_pkg::grp_res_t               res
);

    logic [vc_pkg::WIDE_BITS-1:0] wide;
    logic [vc_pkg::WIDE_BITS-1:0] placed_wide;
    logic [63:0]                  mask64;
    logic [VALUE_BITS-1:0]        mask;

    assign wide   = vc_pkg::WIDE_BITS'(word);
    assign mask64 = vc_pkg::hi_mask64(req.mask_idx);
    assign mask   = mask64[VALUE_BITS-1:0];

    // Select the group at the requested position, both ways
    always_comb
    begin
        res.group   = '0;
        placed_wide = '0;
        for (int k = 0; k < vc_pkg::MAX_GROUPS; k++) begin
            if (req.grp_idx == 4'(k))
            begin
                res.group = wide[vc_pkg::GROUP_BITS*k +: vc_pkg::GROUP_BITS];
                placed_wide[vc_pkg::GROUP_BITS*k +: vc_pkg::GROUP_BITS] = grp;
            end
        end
    end

    assign placed    = placed_wide[VALUE_BITS-1:0];
    assign res.hi_nz = |(word & mask);

endmodule

// ===== sv/varint_codec_top.sv =====
// Unsigned LEB128 varint codec top level: stream ports, sequencer, decode
// state and output register. Uses vc_pkg and vc_group_unit.
// Encode: accept, a capacity check in ST_ENC_CHECK, then one byte per cycle
//   from ST_ENC_EMIT while the output is free; no new input is accepted until
//   the last byte (n = 1..10 bytes) or a capacity error has been loaded.
// Decode: each byte is accepted in ST_IDLE, then passes the group unit in ST_DEC;
//   the final byte's result is loaded into the output register from ST_DEC.
// All steps share the single group unit; a stalled output holds encode and final decode.
// Reset (rst_n low, async) clears decode state, sequencer and output valid;
// decode limit resets to 64 bits and encode capacity to 10 bytes.
`timescale 1ns / 1ps

module varint_codec_top #(
    parameter int VALUE_BITS = vc_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [vc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [vc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,  // in_value[63:0], in_byte[71:64]
    input  logic [0:0]                         s_axis_tuser,  // func[0]
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [vc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,  // out_byte[7:0], out_value[71:8]
    output logic [1:0]                         m_axis_tuser,  // is_value[0], error[1]
    output logic                               m_axis_tlast   // last_of_run
);

    localparam int GB = vc_pkg::GROUP_BITS;

    vc_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic        dec_lim64_reg;
    logic [3:0]  enc_cap_reg;

    // Working registers
    logic [VALUE_BITS-1:0] word_reg, word_next;
    logic [7:0]            byte_reg, byte_next;
    logic [3:0]            idx_reg, idx_next;

    // Decode state
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [3:0]            dec_cnt_reg, dec_cnt_next;
    logic                  dec_ovf_reg, dec_ovf_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic                  out_isv_reg, out_isv_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_err_reg, out_err_next;

    logic                  out_free;
    logic                  in_xfer;

    vc_pkg::grp_req_t      unit_req;
    vc_pkg::grp_res_t      unit_res;
    logic [VALUE_BITS-1:0] unit_placed;

    logic [6:0]            dec_total;
    logic [6:0]            dec_limit;
    logic                  dec_err;

    // Shared group unit
    vc_group_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_group (
        .word   (word_reg),
        .grp    (byte_reg[GB-1:0]),
        .req    (unit_req),
        .placed (unit_placed),
        .res    (unit_res)
    );

    assign s_axis_tready = (state_reg == vc_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Decode limit check: significant bits so far plus the final group
    always_comb
    begin
        dec_total = 7'(dec_cnt_reg) * 7'(GB) + 7'(vc_pkg::bit_len7(byte_reg[GB-1:0]));
        dec_limit = dec_lim64_reg ? 7'(vc_pkg::LIMIT_64) : 7'(vc_pkg::LIMIT_32);
        if (dec_limit > 7'(VALUE_BITS))
        begin
            dec_limit = 7'(VALUE_BITS);
        end
        dec_err = dec_ovf_reg || (dec_total > dec_limit);
    end

    // Sequencer: next state, unit requests and output loads
    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        byte_next      = byte_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        dec_cnt_next   = dec_cnt_reg;
        dec_ovf_next   = dec_ovf_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_value_next = out_value_reg;
        out_isv_next   = out_isv_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        unit_req       = '0;

        unique case (state_reg)
            vc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    word_next = s_axis_tdata[VALUE_BITS-1:0];
                    byte_next = s_axis_tdata[71:64];
                    idx_next  = '0;
                    if (s_axis_tuser == vc_pkg::FUNC_DECODE)
                    begin
                        state_next = vc_pkg::ST_DEC;
                    end
                    else
                    begin
                        state_next = vc_pkg::ST_ENC_CHECK;
                    end
                end
            end

            vc_pkg::ST_ENC_CHECK:
            begin
                // Any bit at or above 7*capacity means too many bytes
                unit_req.mask_idx = enc_cap_reg;
                if ((enc_cap_reg == 4'd0) || unit_res.hi_nz)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_value_next = '0;
                        out_isv_next   = 1'b0;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b1;
                        state_next     = vc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = vc_pkg::ST_ENC_EMIT;
                end
            end

            vc_pkg::ST_ENC_EMIT:
            begin
                // Emit group idx; it is the last if nothing is set above it
                unit_req.grp_idx  = idx_reg;
                unit_req.mask_idx = idx_reg + 4'd1;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {unit_res.hi_nz, unit_res.group};
                    out_value_next = '0;
                    out_isv_next   = 1'b0;
                    out_last_next  = !unit_res.hi_nz;
                    out_err_next   = 1'b0;
                    idx_next       = idx_reg + 4'd1;
                    if (!unit_res.hi_nz)
                    begin
                        state_next = vc_pkg::ST_IDLE;
                    end
                end
            end

            vc_pkg::ST_DEC:
            begin
                unit_req.grp_idx = dec_cnt_reg;
                if (byte_reg[7])
                begin
                    // Continuation byte: collect group, count, flag overflow
                    acc_next     = acc_reg | unit_placed;
                    dec_cnt_next = (dec_cnt_reg == 4'hF) ? 4'hF : dec_cnt_reg + 4'd1;
                    dec_ovf_next = dec_ovf_reg || (dec_cnt_next >= 4'(vc_pkg::MAX_GROUPS));
                    state_next   = vc_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    // Final byte: report value or overflow, then clear
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_value_next = dec_err ? '0 : (acc_reg | unit_placed);
                    out_isv_next   = 1'b1;
                    out_last_next  = 1'b1;
                    out_err_next   = dec_err;
                    acc_next       = '0;
                    dec_cnt_next   = '0;
                    dec_ovf_next   = 1'b0;
                    state_next     = vc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vc_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control and decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vc_pkg::ST_IDLE;
            acc_reg       <= '0;
            dec_cnt_reg   <= '0;
            dec_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            dec_cnt_reg   <= dec_cnt_next;
            dec_ovf_reg   <= dec_ovf_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_lim64_reg <= 1'b1;
            enc_cap_reg   <= 4'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vc_pkg::CFG_DECODE_LIMIT: dec_lim64_reg <= cfg_data[0];
                vc_pkg::CFG_ENCODE_CAP:   enc_cap_reg   <= cfg_data[3:0];
                default:                  dec_lim64_reg <= dec_lim64_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        byte_reg      <= byte_next;
        out_byte_reg  <= out_byte_next;
        out_value_reg <= out_value_next;
        out_isv_reg   <= out_isv_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {64'(out_value_reg), out_byte_reg};
    assign m_axis_tuser  = {out_err_reg, out_isv_reg};
    assign m_axis_tlast  = out_last_reg;

    // Error results always close their run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("error result without last_of_run");

    // Decode results carry no encoded byte
    a_val_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("decode result with nonzero byte");

    // Overflow only once ten continuation groups were seen
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        dec_ovf_reg |-> (dec_cnt_reg >= 4'(vc_pkg::MAX_GROUPS)))
        else $error("decode overflow below group limit");

    // Encoder never walks past the last group
    a_enc_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vc_pkg::ST_ENC_EMIT) |-> (idx_reg < 4'(vc_pkg::MAX_GROUPS)))
        else $error("encode group index out of range");

endmodule
